>>> hw/rtl/assert_macros.svh
// assertion helpers for irprop_plus_weight_update
// each macro expects clk and rst in scope
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hw/rtl/irpp_pkg.sv
`default_nettype none

package irpp_pkg;

  // weight table size
  localparam int NUM_WEIGHTS = 4096;
  localparam int ADDR_W      = (NUM_WEIGHTS > 1) ? $clog2(NUM_WEIGHTS) : 1;

  // field widths
  localparam int OP_W      = 2;
  localparam int INDEX_W   = 12;
  localparam int DATA_W    = 32;
  localparam int STEP_W    = 31;
  localparam int FACTOR_W  = 16;
  localparam int ERR_W     = 48;
  localparam int REG_IDX_W = 3;
  localparam int CFG_W     = 31;

  // fraction bits of the scale factors
  localparam int FACTOR_FRAC = 14;

  localparam logic [STEP_W-1:0] STEP_MAX = {STEP_W{1'b1}};

  // operation codes of an input word
  typedef enum logic [OP_W-1:0] {
    OP_SLOPE     = 2'd0,
    OP_UPDATE    = 2'd1,
    OP_END_BATCH = 2'd2
  } op_t;

  // stored gradient sign
  typedef enum logic [1:0] {
    SIGN_NONE = 2'd0,
    SIGN_POS  = 2'd1,
    SIGN_NEG  = 2'd2
  } sign_t;

  // configuration register indexes
  localparam logic [REG_IDX_W-1:0] REG_GROW_FACTOR   = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_SHRINK_FACTOR = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_MAX_STEP      = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_MIN_STEP      = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_INITIAL_STEP  = 3'd4;

  // configuration register reset values
  localparam logic [FACTOR_W-1:0] GROW_FACTOR_RST   = 16'd19661;
  localparam logic [FACTOR_W-1:0] SHRINK_FACTOR_RST = 16'd8192;
  localparam logic [STEP_W-1:0]   MAX_STEP_RST      = 31'd3276800;
  localparam logic [STEP_W-1:0]   MIN_STEP_RST      = 31'd1;
  localparam logic [STEP_W-1:0]   INITIAL_STEP_RST  = 31'd6554;

  typedef struct packed {
    logic [FACTOR_W-1:0] grow_factor;
    logic [FACTOR_W-1:0] shrink_factor;
    logic [STEP_W-1:0]   max_step;
    logic [STEP_W-1:0]   min_step;
    logic [STEP_W-1:0]   initial_step;
  } cfg_t;

  // one row of the per-weight table
  typedef struct packed {
    logic               seen;
    sign_t              sign;
    logic [STEP_W-1:0]  step;
    logic [DATA_W-1:0]  change;
  } row_t;

  // update result and case flags
  typedef struct packed {
    row_t              row;
    logic [DATA_W-1:0] weight;
    logic              grow;
    logic              shrink;
  } upd_t;

endpackage

`default_nettype wire

>>> hw/rtl/irpp_in_if.sv
`default_nettype none

interface irpp_in_if;
  import irpp_pkg::*;

  logic                valid;
  logic                ready;
  logic [OP_W-1:0]     op;
  logic [INDEX_W-1:0]  weight_index;
  logic [DATA_W-1:0]   value;
  logic [DATA_W-1:0]   weight_in;

  modport source (output valid, output op, output weight_index, output value,
                  output weight_in, input ready);
  modport sink (input valid, input op, input weight_index, input value,
                input weight_in, output ready);
endinterface

`default_nettype wire

>>> hw/rtl/irpp_out_if.sv
`default_nettype none

interface irpp_out_if;
  import irpp_pkg::*;

  logic                valid;
  logic                ready;
  logic [INDEX_W-1:0]  index_out;
  logic [DATA_W-1:0]   weight_out;

  modport source (output valid, output index_out, output weight_out, input ready);
  modport sink (input valid, input index_out, input weight_out, output ready);
endinterface

`default_nettype wire

>>> hw/rtl/irpp_update.sv
`default_nettype none

module irpp_update (
  input  irpp_pkg::cfg_t                cfg,
  input  irpp_pkg::row_t                row,
  input  logic [irpp_pkg::DATA_W-1:0]   value,
  input  logic [irpp_pkg::DATA_W-1:0]   weight_in,
  input  logic                          err_rose,
  output irpp_pkg::upd_t                upd
);
  import irpp_pkg::*;

  localparam int PROD_W = STEP_W + FACTOR_W;
  localparam int SCL_W  = PROD_W - FACTOR_FRAC;

  sign_t                    gs;
  logic                     grow;
  logic                     shrink;
  logic [STEP_W-1:0]        step_cur;
  logic [FACTOR_W-1:0]      factor;
  logic [PROD_W-1:0]        prod;
  logic [SCL_W-1:0]         scaled_wide;
  logic [STEP_W-1:0]        scaled;
  logic [STEP_W-1:0]        step_grow;
  logic [STEP_W-1:0]        step_shrink;
  logic [STEP_W-1:0]        step_new;
  logic signed [DATA_W-1:0] move;
  logic signed [DATA_W-1:0] addend;
  logic signed [DATA_W:0]   sum;

  // gradient sign and case selection
  always_comb begin
    if (value[DATA_W-1]) begin
      gs = SIGN_NEG;
    end else if (value != '0) begin
      gs = SIGN_POS;
    end else begin
      gs = SIGN_NONE;
    end
  end

  assign grow     = (gs != SIGN_NONE) && (row.sign == gs);
  assign shrink   = (gs != SIGN_NONE) && (row.sign != SIGN_NONE) && !grow;
  assign step_cur = row.seen ? row.step : cfg.initial_step;

  // step scaling, one shared multiplier, saturated to the step range
  assign factor      = grow ? cfg.grow_factor : cfg.shrink_factor;
  assign prod        = PROD_W'(step_cur) * PROD_W'(factor);
  assign scaled_wide = prod[PROD_W-1:FACTOR_FRAC];
  assign scaled      = (|scaled_wide[SCL_W-1:STEP_W]) ? STEP_MAX : scaled_wide[STEP_W-1:0];

  // clamps
  assign step_grow   = (scaled < cfg.max_step) ? scaled : cfg.max_step;
  assign step_shrink = (scaled > cfg.min_step) ? scaled : cfg.min_step;

  always_comb begin
    if (grow) begin
      step_new = step_grow;
    end else if (shrink) begin
      step_new = step_shrink;
    end else begin
      step_new = step_cur;
    end
  end

  // weight move in the direction of the gradient
  always_comb begin
    case (gs)
      SIGN_POS: move = $signed({1'b0, step_new});
      SIGN_NEG: move = -$signed({1'b0, step_new});
      default:  move = '0;
    endcase
  end

  // sign change: undo the last change only when the error rose
  always_comb begin
    if (shrink) begin
      addend = err_rose ? $signed(row.change) : '0;
    end else begin
      addend = move;
    end
  end

  assign sum = $signed({weight_in[DATA_W-1], weight_in}) + $signed({addend[DATA_W-1], addend});

  // saturated weight and new table row
  always_comb begin
    if (sum[DATA_W] != sum[DATA_W-1]) begin
      upd.weight = sum[DATA_W] ? {1'b1, {(DATA_W-1){1'b0}}} : {1'b0, {(DATA_W-1){1'b1}}};
    end else begin
      upd.weight = sum[DATA_W-1:0];
    end
    upd.row.seen   = 1'b1;
    upd.row.sign   = shrink ? SIGN_NONE : gs;
    upd.row.step   = step_new;
    upd.row.change = shrink ? row.change : DATA_W'(-move);
    upd.grow       = grow;
    upd.shrink     = shrink;
  end

endmodule

`default_nettype wire

>>> hw/rtl/irprop_plus_weight_update.sv
// iRprop+ weight update, Q16.16 fixed point.
// in_ch takes words of three kinds: a slope sample is added to the batch
// error, an update word (index, gradient, current weight) gives one result
// word on out_ch with the index and the new weight, and an end-of-batch
// word saves the batch error and clears the sum. Other words give nothing.
// The configuration port writes the scale factors and step limits; the user
// must write only while no word is in flight, the block does not enforce it.
// An update word is registered into the table read and the compute stage at
// its input edge, and its result into the output register when that stage advances.
// Throughput is one word per cycle while out_ch does not stall; the per-weight
// table does one read and one write each cycle and a bypass covers
// back-to-back updates of the same weight.
// Reset: after rst the table of per-weight state is cleared one row a cycle,
// all NUM_WEIGHTS (4096) rows, with in_ch.ready low; configuration writes are
// taken during that time.
// When out_ch stalls, the output register holds its word, the compute stage
// holds the next one and, once it does, in_ch.ready drops until the output drains.
`default_nettype none
`include "assert_macros.svh"

module irprop_plus_weight_update (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic [irpp_pkg::REG_IDX_W-1:0]   cfg_index,
  input  logic [irpp_pkg::CFG_W-1:0]       cfg_data,
  irpp_in_if.sink                          in_ch,
  irpp_out_if.source                       out_ch
);
  import irpp_pkg::*;

  cfg_t                     cfg;
  logic signed [ERR_W-1:0]  error_sum;
  logic signed [ERR_W-1:0]  previous_error;
  logic signed [ERR_W:0]    err_add;

  logic [ADDR_W-1:0]        clr_cnt;
  logic                     clr_done;

  row_t                     mem [NUM_WEIGHTS];
  row_t                     rd_row;
  row_t                     fwd_row;
  logic                     fwd_hit;
  row_t                     cur_row;

  logic                     s1_valid;
  logic [INDEX_W-1:0]       s1_index;
  logic [DATA_W-1:0]        s1_value;
  logic [DATA_W-1:0]        s1_weight;
  logic [ADDR_W-1:0]        s1_addr;
  logic                     s1_adv;

  logic                     out_valid;
  logic [INDEX_W-1:0]       out_index;
  logic [DATA_W-1:0]        out_weight;

  logic                     in_fire;
  logic                     in_range;
  logic                     upd_fire;
  logic [ADDR_W-1:0]        in_addr;
  logic                     err_rose;
  upd_t                     upd;

  // handshake
  assign s1_adv      = s1_valid && (!out_valid || out_ch.ready);
  assign in_ch.ready = clr_done && (!s1_valid || s1_adv);
  assign in_fire     = in_ch.valid && in_ch.ready;
  assign in_range    = 32'(in_ch.weight_index) < 32'(NUM_WEIGHTS);
  assign upd_fire    = in_fire && (in_ch.op == OP_UPDATE) && in_range;
  assign in_addr     = ADDR_W'(in_ch.weight_index);
  assign s1_addr     = ADDR_W'(s1_index);

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.grow_factor   <= GROW_FACTOR_RST;
      cfg.shrink_factor <= SHRINK_FACTOR_RST;
      cfg.max_step      <= MAX_STEP_RST;
      cfg.min_step      <= MIN_STEP_RST;
      cfg.initial_step  <= INITIAL_STEP_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_GROW_FACTOR:   cfg.grow_factor   <= cfg_data[FACTOR_W-1:0];
        REG_SHRINK_FACTOR: cfg.shrink_factor <= cfg_data[FACTOR_W-1:0];
        REG_MAX_STEP:      cfg.max_step      <= cfg_data[STEP_W-1:0];
        REG_MIN_STEP:      cfg.min_step      <= cfg_data[STEP_W-1:0];
        REG_INITIAL_STEP:  cfg.initial_step  <= cfg_data[STEP_W-1:0];
        default: ;
      endcase
    end
  end

  // batch error, saturating at the 48-bit limits
  assign err_add = $signed({error_sum[ERR_W-1], error_sum})
                 + $signed((ERR_W + 1)'($signed(in_ch.value)));

  always_ff @(posedge clk) begin
    if (rst) begin
      error_sum      <= '0;
      previous_error <= '0;
    end else if (in_fire) begin
      case (in_ch.op)
        OP_SLOPE: begin
          if (err_add[ERR_W] != err_add[ERR_W-1]) begin
            error_sum <= err_add[ERR_W] ? {1'b1, {(ERR_W-1){1'b0}}}
                                        : {1'b0, {(ERR_W-1){1'b1}}};
          end else begin
            error_sum <= err_add[ERR_W-1:0];
          end
        end
        OP_END_BATCH: begin
          previous_error <= error_sum;
          error_sum      <= '0;
        end
        default: ;
      endcase
    end
  end

  assign err_rose = error_sum > previous_error;

  // table clearing pass after reset
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_cnt  <= '0;
      clr_done <= 1'b0;
    end else if (!clr_done) begin
      clr_cnt <= clr_cnt + ADDR_W'(1);
      if (clr_cnt == ADDR_W'(NUM_WEIGHTS - 1)) begin
        clr_done <= 1'b1;
      end
    end
  end

  // per-weight table: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (!clr_done) begin
      mem[clr_cnt] <= row_t'('0);
    end else if (s1_adv) begin
      mem[s1_addr] <= upd.row;
    end
    if (upd_fire) begin
      rd_row <= mem[in_addr];
    end
  end

  // bypass for an update of the row being written at the read edge
  always_ff @(posedge clk) begin
    if (upd_fire) begin
      fwd_hit <= s1_adv && (s1_addr == in_addr);
      fwd_row <= upd.row;
    end
  end

  assign cur_row = fwd_hit ? fwd_row : rd_row;

  // compute stage
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (upd_fire) begin
      s1_valid <= 1'b1;
    end else if (s1_adv) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (upd_fire) begin
      s1_index  <= in_ch.weight_index;
      s1_value  <= in_ch.value;
      s1_weight <= in_ch.weight_in;
    end
  end

  irpp_update u_update (
    .cfg       (cfg),
    .row       (cur_row),
    .value     (s1_value),
    .weight_in (s1_weight),
    .err_rose  (err_rose),
    .upd       (upd)
  );

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_adv) begin
      out_valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_index  <= s1_index;
      out_weight <= upd.weight;
    end
  end

  assign out_ch.valid      = out_valid;
  assign out_ch.index_out  = out_index;
  assign out_ch.weight_out = out_weight;

  // checks
  `ASSERT_NEXT(a_result_follows, s1_adv, out_valid, "computed word lost before output")
  `ASSERT_IMPL(a_grow_clamp, s1_valid && upd.grow, upd.row.step <= cfg.max_step, "step above max")
  `ASSERT_IMPL(a_shrink_clamp, s1_valid && upd.shrink, upd.row.step >= cfg.min_step, "step below min")
  `ASSERT_IMPL(a_clear_len, $rose(clr_done), $past(clr_cnt) == ADDR_W'(NUM_WEIGHTS - 1), "clear short")

endmodule

`default_nettype wire

>>> verif/tb_top.sv
`default_nettype none

module tb_top;
  import irpp_pkg::*;

  // op code with no meaning, the block drops such words
  localparam logic [OP_W-1:0] OP_RESERVED = 2'd3;

  localparam int     N_PHASES        = 6;
  localparam int     RAND_PER_PHASE  = 140;
  localparam int     SETTLE_CYCLES   = 6;
  localparam longint ERR_HI          = 64'sh0000_7FFF_FFFF_FFFF;
  localparam longint ERR_LO          = -ERR_HI - 1;
  localparam longint W_HI            = 64'sh0000_0000_7FFF_FFFF;
  localparam longint W_LO            = -W_HI - 1;

  typedef struct {
    logic [OP_W-1:0]    op;
    logic [INDEX_W-1:0] idx;
    logic [DATA_W-1:0]  value;
    logic [DATA_W-1:0]  weight;
  } in_word_t;

  typedef struct {
    logic [INDEX_W-1:0] idx;
    logic [DATA_W-1:0]  weight;
  } new_weight_t;

  typedef enum {RX_FREE, RX_COIN, RX_EVERY_THIRD, RX_HOLD} rx_mode_t;

  logic clk = 1'b0;
  logic rst;
  logic cfg_we;
  logic [REG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0] cfg_data;

  irpp_in_if  in_ch();
  irpp_out_if out_ch();

  irprop_plus_weight_update u_top (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_ch     (in_ch),
    .out_ch    (out_ch)
  );

  // clock, period 2
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  in_word_t    pending_words[$];
  new_weight_t expected_weights[$];

  // predicted block state
  logic [FACTOR_W-1:0] grow_f, shrink_f;
  logic [STEP_W-1:0]   max_s, min_s, init_s;
  longint              err_sum, prev_err;
  sign_t               sign_tbl [NUM_WEIGHTS];
  logic [31:0]         step_tbl [NUM_WEIGHTS];
  int                  change_tbl [NUM_WEIGHTS];
  logic                seen_tbl [NUM_WEIGHTS];

  int mismatch_cnt = 0;
  int n_update = 0, n_slope = 0, n_batch = 0, n_ignored = 0, n_checked = 0;

  logic     in_acc = 1'b0;
  in_word_t drive_word;
  int       gap_left = 0, burst_left = 0;
  rx_mode_t rx_mode = RX_FREE;
  int       rx_left = 0, rx_tick = 0;

  function automatic void flag_mismatch(string msg);
    if (mismatch_cnt < 10) $display("mismatch: %s", msg);
    mismatch_cnt++;
  endfunction

  function automatic logic [31:0] sat32(longint x);
    if (x > W_HI) return 32'h7FFF_FFFF;
    if (x < W_LO) return 32'h8000_0000;
    return x[31:0];
  endfunction

  // step * factor in Q2.14, truncated, saturated to 31 bits
  function automatic logic [31:0] scale_step(logic [31:0] s, logic [FACTOR_W-1:0] f);
    logic [63:0] p;
    p = ({32'd0, s} * {48'd0, f}) >> FACTOR_FRAC;
    if (p > 64'h7FFF_FFFF) return 32'h7FFF_FFFF;
    return p[31:0];
  endfunction

  // iRprop+ update of the predicted state for one accepted word
  task automatic irprop_step(input in_word_t w);
    longint      grad, wcur, nw;
    sign_t       gs, ls;
    logic [31:0] step, scaled;
    int          chg;
    new_weight_t r;
    grad = longint'($signed(w.value));
    wcur = longint'($signed(w.weight));
    nw = wcur;
    case (w.op)
      OP_SLOPE: begin
        err_sum = err_sum + grad;
        if (err_sum > ERR_HI) err_sum = ERR_HI;
        else if (err_sum < ERR_LO) err_sum = ERR_LO;
        n_slope++;
      end
      OP_END_BATCH: begin
        prev_err = err_sum;
        err_sum = 0;
        n_batch++;
      end
      OP_UPDATE: begin
        if (grad > 0) gs = SIGN_POS;
        else if (grad < 0) gs = SIGN_NEG;
        else gs = SIGN_NONE;
        ls = sign_tbl[w.idx];
        step = seen_tbl[w.idx] ? step_tbl[w.idx] : {1'b0, init_s};
        if (gs != SIGN_NONE && ls == gs) begin
          // same sign: grow the step and move
          scaled = scale_step(step, grow_f);
          step = (scaled < {1'b0, max_s}) ? scaled : {1'b0, max_s};
          chg = (gs == SIGN_POS) ? -int'(step) : int'(step);
          nw = wcur - chg;
          sign_tbl[w.idx] = gs;
        end else if (gs != SIGN_NONE && ls != SIGN_NONE) begin
          // sign flip: shrink, undo last change only when the error rose
          scaled = scale_step(step, shrink_f);
          step = (scaled > {1'b0, min_s}) ? scaled : {1'b0, min_s};
          chg = change_tbl[w.idx];
          if (err_sum > prev_err) nw = wcur + chg;
          sign_tbl[w.idx] = SIGN_NONE;
        end else begin
          // no stored sign or zero gradient: plain move
          if (gs == SIGN_NONE) chg = 0;
          else chg = (gs == SIGN_POS) ? -int'(step) : int'(step);
          nw = wcur - chg;
          sign_tbl[w.idx] = gs;
        end
        step_tbl[w.idx] = step;
        change_tbl[w.idx] = chg;
        seen_tbl[w.idx] = 1'b1;
        r.idx = w.idx;
        r.weight = sat32(nw);
        expected_weights.push_back(r);
        n_update++;
      end
      default: n_ignored++;
    endcase
  endtask

  // sender: bursts of words with random gaps
  always @(negedge clk) begin
    if (rst) begin
      in_ch.valid <= 1'b0;
    end else if (!in_ch.valid || in_acc) begin
      if (gap_left > 0) begin
        gap_left--;
        in_ch.valid <= 1'b0;
      end else if (pending_words.size() != 0) begin
        drive_word = pending_words.pop_front();
        in_ch.op <= drive_word.op;
        in_ch.weight_index <= drive_word.idx;
        in_ch.value <= drive_word.value;
        in_ch.weight_in <= drive_word.weight;
        in_ch.valid <= 1'b1;
        if (burst_left > 1) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(1, 24);
          gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
        end
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // receiver: stall pattern changes mode after a run of random length
  always @(negedge clk) begin
    if (rx_left == 0) begin
      rx_mode = rx_mode_t'($urandom_range(0, 3));
      rx_left = $urandom_range(8, 64);
    end
    rx_left--;
    rx_tick++;
    case (rx_mode)
      RX_FREE:        out_ch.ready <= 1'b1;
      RX_COIN:        out_ch.ready <= 1'($urandom_range(0, 1));
      RX_EVERY_THIRD: out_ch.ready <= (rx_tick % 3 == 0);
      default:        out_ch.ready <= 1'b0;
    endcase
  end

  // monitor: config writes, result checks, prediction of accepted words
  always @(posedge clk) begin
    new_weight_t exp_w;
    in_word_t    got;
    in_acc <= (in_ch.valid === 1'b1) && (in_ch.ready === 1'b1);
    if (!rst) begin
      if (cfg_we) begin
        case (cfg_index)
          REG_GROW_FACTOR:   grow_f = cfg_data[FACTOR_W-1:0];
          REG_SHRINK_FACTOR: shrink_f = cfg_data[FACTOR_W-1:0];
          REG_MAX_STEP:      max_s = cfg_data[STEP_W-1:0];
          REG_MIN_STEP:      min_s = cfg_data[STEP_W-1:0];
          REG_INITIAL_STEP:  init_s = cfg_data[STEP_W-1:0];
          default: ;
        endcase
      end
      if (out_ch.valid === 1'b1 && out_ch.ready) begin
        if (expected_weights.size() == 0) begin
          flag_mismatch($sformatf("unexpected word index %0d weight %h",
                                  out_ch.index_out, out_ch.weight_out));
        end else begin
          exp_w = expected_weights.pop_front();
          n_checked++;
          if (out_ch.index_out !== exp_w.idx)
            flag_mismatch($sformatf("index_out expected %0d actual %0d",
                                    exp_w.idx, out_ch.index_out));
          if (out_ch.weight_out !== exp_w.weight)
            flag_mismatch($sformatf("weight_out idx %0d expected %h actual %h",
                                    exp_w.idx, exp_w.weight, out_ch.weight_out));
        end
      end
      if (in_ch.valid && in_ch.ready === 1'b1) begin
        got.op = in_ch.op;
        got.idx = in_ch.weight_index;
        got.value = in_ch.value;
        got.weight = in_ch.weight_in;
        irprop_step(got);
      end
    end
  end

  function automatic void push_word(logic [OP_W-1:0] op, logic [INDEX_W-1:0] idx,
                                    logic [DATA_W-1:0] value, logic [DATA_W-1:0] weight);
    in_word_t w;
    w.op = op;
    w.idx = idx;
    w.value = value;
    w.weight = weight;
    pending_words.push_back(w);
  endfunction

  function automatic logic [31:0] rand_small(int span);
    return $urandom_range(0, 2 * span) - span;
  endfunction

  // gradient: some zeros, mostly small, sometimes full range
  function automatic logic [31:0] rand_grad();
    logic [31:0] mag;
    if ($urandom_range(0, 9) == 0) return 32'd0;
    if ($urandom_range(0, 3) == 0) return $urandom;
    mag = $urandom_range(1, 1 << 20);
    return $urandom_range(0, 1) ? -mag : mag;
  endfunction

  function automatic logic [31:0] rand_weight();
    if ($urandom_range(0, 4) == 0) return $urandom;
    return rand_small(1 << 20);
  endfunction

  task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // hold off until every word is through and the pipeline has settled
  task automatic wait_drained();
    @(posedge clk);
    while (pending_words.size() != 0 || in_ch.valid || expected_weights.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // run limit
  initial begin
    #1000000;
    $display("irprop_plus_weight_update test failed");
    $finish;
  end

  // stimulus and end of run
  initial begin
    logic [FACTOR_W-1:0] set_grow, set_shrink;
    logic [STEP_W-1:0]   set_max, set_min, set_init;
    logic [INDEX_W-1:0]  pool [6];
    logic [INDEX_W-1:0]  last_idx;
    logic [OP_W-1:0]     noise_op;
    int                  cnt, n, m;

    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    in_ch.valid = 1'b0;
    in_ch.op = OP_SLOPE;
    in_ch.weight_index = '0;
    in_ch.value = '0;
    in_ch.weight_in = '0;
    out_ch.ready = 1'b0;

    grow_f = GROW_FACTOR_RST;
    shrink_f = SHRINK_FACTOR_RST;
    max_s = MAX_STEP_RST;
    min_s = MIN_STEP_RST;
    init_s = INITIAL_STEP_RST;
    err_sum = 0;
    prev_err = 0;
    for (int k = 0; k < NUM_WEIGHTS; k++) begin
      sign_tbl[k] = SIGN_NONE;
      step_tbl[k] = '0;
      change_tbl[k] = 0;
      seen_tbl[k] = 1'b0;
    end

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    for (int p = 0; p < N_PHASES; p++) begin
      if (p > 0) wait_drained();

      // register setting of this phase, extremes first
      case (p)
        0: begin
          set_grow = GROW_FACTOR_RST;
          set_shrink = SHRINK_FACTOR_RST;
          set_max = MAX_STEP_RST;
          set_min = MIN_STEP_RST;
          set_init = INITIAL_STEP_RST;
        end
        1: begin
          set_grow = '1;
          set_shrink = '1;
          set_max = STEP_MAX;
          set_min = '0;
          set_init = STEP_MAX;
        end
        2: begin
          set_grow = '0;
          set_shrink = '0;
          set_max = '0;
          set_min = '0;
          set_init = '0;
        end
        3: begin
          set_grow = 16'd16384;
          set_shrink = '0;
          set_max = 31'd1000;
          set_min = STEP_MAX;
          set_init = 31'd50;
        end
        default: begin
          set_grow = FACTOR_W'($urandom_range(16384, 32767));
          set_shrink = FACTOR_W'($urandom_range(4096, 16383));
          set_max = STEP_W'($urandom_range(1, 1 << 24));
          set_min = STEP_W'($urandom_range(0, 255));
          set_init = STEP_W'($urandom_range(1, 1 << 20));
        end
      endcase
      write_reg(REG_GROW_FACTOR, CFG_W'(set_grow));
      write_reg(REG_SHRINK_FACTOR, CFG_W'(set_shrink));
      write_reg(REG_MAX_STEP, set_max);
      write_reg(REG_MIN_STEP, set_min);
      write_reg(REG_INITIAL_STEP, set_init);

      if (p == 0) begin
        // slope extremes, error ends at -1
        push_word(OP_SLOPE, '0, 32'h7FFF_FFFF, '0);
        push_word(OP_SLOPE, '1, 32'h8000_0000, '1);
        push_word(OP_SLOPE, '0, 32'd0, '0);
        // unused op with every bit set
        push_word(OP_RESERVED, '1, '1, '1);
        // first update, then same sign, then sign flip with error not risen
        push_word(OP_UPDATE, 12'd0, 32'd1, 32'd0);
        push_word(OP_UPDATE, 12'd0, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        push_word(OP_UPDATE, 12'd0, 32'hFFFF_FFFF, 32'h1234_5678);
        push_word(OP_UPDATE, 12'd0, -32'sd5, 32'd0);
        // zero gradient on a fresh weight, then a move into low saturation
        push_word(OP_UPDATE, 12'd4095, 32'd0, 32'h8000_0000);
        push_word(OP_UPDATE, 12'd4095, 32'h8000_0000, 32'h8000_0000);
        // error rises, sign flip undoes the last change into high saturation
        push_word(OP_END_BATCH, '0, '0, '0);
        push_word(OP_SLOPE, '0, 32'd5, '0);
        push_word(OP_UPDATE, 12'd4095, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        push_word(OP_UPDATE, 12'd4095, 32'd1, 32'd0);
        push_word(OP_UPDATE, 12'd4095, 32'd1, 32'd0);
        push_word(OP_UPDATE, 12'd4095, 32'd0, 32'd0);
        // error falls, back-to-back updates of one weight
        push_word(OP_END_BATCH, '1, '1, '1);
        push_word(OP_SLOPE, '0, -32'sd3, '0);
        push_word(OP_UPDATE, 12'd7, 32'd1000, 32'h0001_0000);
        push_word(OP_UPDATE, 12'd7, 32'd2000, 32'h0001_0000);
        push_word(OP_UPDATE, 12'd7, 32'hFFFF_FFFF, 32'h0001_0000);
        // alternating bit patterns
        push_word(OP_UPDATE, 12'hAAA, 32'h5555_5555, 32'hAAAA_AAAA);
        push_word(OP_UPDATE, 12'h555, 32'hAAAA_AAAA, 32'h5555_5555);
        push_word(OP_END_BATCH, '0, '0, '0);
      end

      // random part: mostly whole batches on a small set of weights
      foreach (pool[k]) pool[k] = INDEX_W'($urandom_range(0, NUM_WEIGHTS - 1));
      if (p % 2 == 1) pool[5] = INDEX_W'(NUM_WEIGHTS - 1);
      else pool[0] = '0;
      last_idx = pool[0];
      cnt = 0;
      while (cnt < RAND_PER_PHASE) begin
        if ($urandom_range(0, 9) < 7) begin
          n = $urandom_range(0, 4);
          m = $urandom_range(1, 8);
          repeat (n) begin
            push_word(OP_SLOPE, INDEX_W'($urandom),
                      ($urandom_range(0, 7) == 0) ? $urandom : rand_small(1 << 16),
                      $urandom);
          end
          repeat (m) begin
            if ($urandom_range(0, 9) >= 3) last_idx = pool[$urandom_range(0, 5)];
            push_word(OP_UPDATE, last_idx, rand_grad(), rand_weight());
          end
          push_word(OP_END_BATCH, INDEX_W'($urandom), $urandom, $urandom);
          cnt += n + m + 1;
        end else begin
          // noise word of any op on any weight
          noise_op = OP_W'($urandom_range(0, 3));
          push_word(noise_op, INDEX_W'($urandom), $urandom, $urandom);
          if (noise_op != OP_RESERVED) cnt++;
        end
      end
    end

    wait_drained();
    if (expected_weights.size() != 0)
      flag_mismatch($sformatf("%0d results never arrived", expected_weights.size()));

    $display("covered %0d weight updates (%0d results checked), %0d slope words,",
             n_update, n_checked, n_slope);
    $display("%0d batch ends and %0d dropped words over %0d register settings",
             n_batch, n_ignored, N_PHASES);
    if (mismatch_cnt == 0) begin
      $display("irprop_plus_weight_update test passed");
    end else begin
      $display("%0d mismatches", mismatch_cnt);
      $display("irprop_plus_weight_update test failed");
    end
    $finish;
  end

endmodule

`default_nettype wire
